// File: rtl/psdf_pkg.sv
// Package with the shared types and defaults of the per-source sequence dedup filter.
`default_nettype none

package psdf_pkg;

  // Default table size and identifier width.
  localparam int TableDepthDef = 16;
  localparam int IdBitsDef     = 64;

  // Fixed field widths of the stream items.
  localparam int SrcPortW  = 64;
  localparam int SeqW      = 32;
  localparam int InDataW   = 104;
  localparam int OutDataW  = 8;

  // Bit positions inside the input tdata.
  localparam int InSeqLsb  = 64;
  localparam int InOpenBit = 96;

  // Bit positions inside the output tdata.
  localparam int OutAccBit   = 0;
  localparam int OutDupBit   = 1;
  localparam int OutFreshBit = 2;
  localparam int OutFullBit  = 3;

  // Search flags that walk down the chain of cells with a query.
  typedef struct packed {
    logic active;      // a query occupies this stage
    logic open;        // requests are accepted for this item
    logic hit;         // a valid entry with the same source was found
    logic dup;         // sequence not newer than the stored one
    logic free_found;  // a free entry was seen
  } tok_t;

  // Table update sent to every cell when a query leaves the chain.
  typedef struct packed {
    logic wr;     // write the selected entry
    logic alloc;  // entry is new: store source and set valid
  } cmt_t;

endpackage

`default_nettype wire

// File: rtl/psdf_cell.sv
// One table entry of the dedup filter together with one stage of the query chain.
`default_nettype none

module psdf_cell #(
  parameter int ID_BITS = psdf_pkg::IdBitsDef,
  parameter int IDX_W   = 4,
  parameter int IDX     = 0
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  // Query coming from the previous cell.
  input  wire psdf_pkg::tok_t            tok_in,
  input  wire logic [ID_BITS-1:0]        src_in,
  input  wire logic [psdf_pkg::SeqW-1:0] seq_in,
  input  wire logic [IDX_W-1:0]          hit_idx_in,
  input  wire logic [IDX_W-1:0]          free_idx_in,
  // Query handed to the next cell.
  output psdf_pkg::tok_t                 tok_out,
  output logic [ID_BITS-1:0]             src_out,
  output logic [psdf_pkg::SeqW-1:0]      seq_out,
  output logic [IDX_W-1:0]               hit_idx_out,
  output logic [IDX_W-1:0]               free_idx_out,
  // Table update broadcast from the top level.
  input  wire psdf_pkg::cmt_t            cmt,
  input  wire logic [IDX_W-1:0]          cmt_idx,
  input  wire logic [ID_BITS-1:0]        cmt_src,
  input  wire logic [psdf_pkg::SeqW-1:0] cmt_seq
);

  localparam logic [IDX_W-1:0] MyIdx = IDX_W'(IDX);

  logic                      valid_r;
  logic [ID_BITS-1:0]        ent_src_r;
  logic [psdf_pkg::SeqW-1:0] ent_seq_r;

  psdf_pkg::tok_t            tok_r, tok_nxt;
  logic [ID_BITS-1:0]        src_r;
  logic [psdf_pkg::SeqW-1:0] seq_r;
  logic [IDX_W-1:0]          hit_idx_r, hit_idx_nxt;
  logic [IDX_W-1:0]          free_idx_r, free_idx_nxt;

  // Compare the passing query with this entry; the lowest match and free slot win.
  always_comb begin
    tok_nxt      = tok_in;
    hit_idx_nxt  = hit_idx_in;
    free_idx_nxt = free_idx_in;
    if (tok_in.active && valid_r && !tok_in.hit && (ent_src_r == src_in)) begin
      tok_nxt.hit = 1'b1;
      tok_nxt.dup = (seq_in <= ent_seq_r);
      hit_idx_nxt = MyIdx;
    end
    if (tok_in.active && !valid_r && !tok_in.free_found) begin
      tok_nxt.free_found = 1'b1;
      free_idx_nxt       = MyIdx;
    end
  end

  // Query stage register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r <= '0;
    end else begin
      tok_r <= tok_nxt;
    end
    src_r      <= src_in;
    seq_r      <= seq_in;
    hit_idx_r  <= hit_idx_nxt;
    free_idx_r <= free_idx_nxt;
  end

  // Entry storage, written by the broadcast update.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (cmt.wr && cmt.alloc && (cmt_idx == MyIdx)) begin
      valid_r <= 1'b1;
    end
    if (cmt.wr && (cmt_idx == MyIdx)) begin
      ent_seq_r <= cmt_seq;
      if (cmt.alloc) begin
        ent_src_r <= cmt_src;
      end
    end
  end

  assign tok_out      = tok_r;
  assign src_out      = src_r;
  assign seq_out      = seq_r;
  assign hit_idx_out  = hit_idx_r;
  assign free_idx_out = free_idx_r;

endmodule

`default_nettype wire

// File: rtl/per_source_sequence_dedup_filter.sv
// Top level of the per-source sequence dedup filter: query chain, table update and output.
//
// Each accepted item becomes a query that walks the row of TABLE_DEPTH cells, one cell per
// cycle; when it leaves the last cell the table is updated and the result is registered in
// the output register, or in the pending slot while the output register is still full. One
// item is in the chain at a time; a new item is taken as soon as the previous result sits in
// the output register, even while that result waits for out_tready. Every source found is
// compared on its low ID_BITS bits. The valid bits are cleared by reset at once; no clearing
// pass is needed.
`default_nettype none

module per_source_sequence_dedup_filter #(
  parameter int TABLE_DEPTH = psdf_pkg::TableDepthDef,
  parameter int ID_BITS     = psdf_pkg::IdBitsDef
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  // Input items.
  input  wire logic                          in_tvalid,
  output logic                               in_tready,
  // From bit 0: source_id[63:0], sequence_number[95:64], requests_open[96], zeros.
  input  wire logic [psdf_pkg::InDataW-1:0]  in_tdata,
  // Result items.
  output logic                               out_tvalid,
  input  wire logic                          out_tready,
  // From bit 0: accepted[0], duplicate[1], fresh[2], table_full[3], zeros.
  output logic [psdf_pkg::OutDataW-1:0]      out_tdata
);

  localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int SEQ_W = psdf_pkg::SeqW;

  // Chain links; link 0 is the injected query, link TABLE_DEPTH the tail.
  psdf_pkg::tok_t     tok  [TABLE_DEPTH+1];
  logic [ID_BITS-1:0] csrc [TABLE_DEPTH+1];
  logic [SEQ_W-1:0]   cseq [TABLE_DEPTH+1];
  logic [IDX_W-1:0]   chit [TABLE_DEPTH+1];
  logic [IDX_W-1:0]   cfree[TABLE_DEPTH+1];

  psdf_pkg::cmt_t     cmt;
  logic [IDX_W-1:0]   cmt_idx;

  logic       in_fire, out_fire, done, out_free;
  logic       busy_r;
  logic       out_valid_r;
  logic [3:0] out_res_r;
  logic       pend_valid_r;
  logic [3:0] pend_res_r;
  logic [3:0] res;
  logic       fresh, full;

  assign in_fire  = in_tvalid && in_tready;
  assign out_fire = out_valid_r && out_tready;
  assign out_free = !out_valid_r || out_fire;
  assign in_tready = !busy_r;

  // Inject the accepted item at the head of the chain.
  always_comb begin
    tok[0]            = '0;
    tok[0].active     = in_fire;
    tok[0].open       = in_tdata[psdf_pkg::InOpenBit];
    csrc[0]           = in_tdata[ID_BITS-1:0];
    cseq[0]           = in_tdata[psdf_pkg::InSeqLsb +: SEQ_W];
    chit[0]           = '0;
    cfree[0]          = '0;
  end

  // Row of table cells.
  for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
    psdf_cell #(
      .ID_BITS (ID_BITS),
      .IDX_W   (IDX_W),
      .IDX     (g)
    ) u_cell (
      .clk          (clk),
      .rst_n        (rst_n),
      .tok_in       (tok[g]),
      .src_in       (csrc[g]),
      .seq_in       (cseq[g]),
      .hit_idx_in   (chit[g]),
      .free_idx_in  (cfree[g]),
      .tok_out      (tok[g+1]),
      .src_out      (csrc[g+1]),
      .seq_out      (cseq[g+1]),
      .hit_idx_out  (chit[g+1]),
      .free_idx_out (cfree[g+1]),
      .cmt          (cmt),
      .cmt_idx      (cmt_idx),
      .cmt_src      (csrc[TABLE_DEPTH]),
      .cmt_seq      (cseq[TABLE_DEPTH])
    );
  end

  // Decide the table update and the result when the query leaves the chain.
  always_comb begin
    done    = tok[TABLE_DEPTH].active;
    fresh   = tok[TABLE_DEPTH].open && !tok[TABLE_DEPTH].dup;
    full    = fresh && !tok[TABLE_DEPTH].hit && !tok[TABLE_DEPTH].free_found;
    cmt     = '0;
    cmt_idx = chit[TABLE_DEPTH];
    if (done && fresh) begin
      if (tok[TABLE_DEPTH].hit) begin
        cmt.wr = 1'b1;
      end else if (tok[TABLE_DEPTH].free_found) begin
        cmt.wr    = 1'b1;
        cmt.alloc = 1'b1;
        cmt_idx   = cfree[TABLE_DEPTH];
      end
    end
    res = {full, fresh, tok[TABLE_DEPTH].dup, tok[TABLE_DEPTH].open};
  end

  // Output register with one pending slot behind it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r       <= 1'b0;
      out_valid_r  <= 1'b0;
      pend_valid_r <= 1'b0;
    end else begin
      priority if (done) begin
        if (out_free) begin
          out_valid_r <= 1'b1;
          busy_r      <= 1'b0;
        end else begin
          pend_valid_r <= 1'b1;
        end
      end else if (pend_valid_r && out_free) begin
        out_valid_r  <= 1'b1;
        pend_valid_r <= 1'b0;
        busy_r       <= 1'b0;
      end else begin
        // A taken result with nothing behind it empties the output register.
        if (out_fire) begin
          out_valid_r <= 1'b0;
        end
        if (in_fire) begin
          busy_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (done && out_free) begin
      out_res_r <= res;
    end else if (pend_valid_r && out_free) begin
      out_res_r <= pend_res_r;
    end
    if (done && !out_free) begin
      pend_res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(psdf_pkg::OutDataW-4){1'b0}}, out_res_r};

endmodule

`default_nettype wire

// File: rtl/psdf_checker.sv
// Port-level checker for the per-source sequence dedup filter and its bind.
`default_nettype none

module psdf_checker (
  input wire logic                         clk,
  input wire logic                         rst_n,
  input wire logic                         in_tvalid,
  input wire logic                         in_tready,
  input wire logic                         out_tvalid,
  input wire logic                         out_tready,
  input wire logic [psdf_pkg::OutDataW-1:0] out_tdata
);

  logic in_fire;
  assign in_fire = in_tvalid && in_tready;

  // A result once shown stays until taken.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result dropped before it was taken");

  // A fresh item is accepted and is no duplicate.
  a_fresh: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[psdf_pkg::OutFreshBit] |->
      out_tdata[psdf_pkg::OutAccBit] && !out_tdata[psdf_pkg::OutDupBit])
    else $error("fresh flag inconsistent with accepted or duplicate");

  // Table full is reported only for a fresh item.
  a_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[psdf_pkg::OutFullBit] |-> out_tdata[psdf_pkg::OutFreshBit])
    else $error("table full reported for an item that is not fresh");

  // Only one item is searched at a time.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> !in_tready)
    else $error("second item taken while a search is under way");

  // No result right after reset.
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result shown after reset");

endmodule

bind per_source_sequence_dedup_filter psdf_checker u_psdf_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

`default_nettype wire
